### rtl/owle_pkg.sv
// Shared types, sizes and codes for the ordered word list engine.
package owle_pkg;

  localparam int CAPACITY  = 16;
  localparam int WORD_BITS = 32;
  localparam int IDX_BITS  = $clog2(CAPACITY);
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [IDX_BITS-1:0]  idx_t;
  typedef logic [CNT_BITS-1:0]  count_t;
  typedef logic [3:0]           mode_t;

  // Operation codes carried in the request mode field
  localparam mode_t MODE_APPEND  = 4'd0;
  localparam mode_t MODE_READ    = 4'd1;
  localparam mode_t MODE_WRITE   = 4'd2;
  localparam mode_t MODE_FIND    = 4'd3;
  localparam mode_t MODE_REMOVE  = 4'd4;
  localparam mode_t MODE_INSERT  = 4'd5;
  localparam mode_t MODE_SWAP    = 4'd6;
  localparam mode_t MODE_SORT    = 4'd7;
  localparam mode_t MODE_REVERSE = 4'd8;
  localparam mode_t MODE_CLEAR   = 4'd9;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef struct packed {
    mode_t mode;
    idx_t  position;
    idx_t  other_position;
    word_t word_in;
  } req_t;

  typedef struct packed {
    status_t status;
    word_t   word_out;
    idx_t    found_at;
    count_t  entries;
  } rsp_t;

  // What every cell of the chain does on each clock edge
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_WRITE,
    CELL_REMOVE,
    CELL_INSERT,
    CELL_SWAP,
    CELL_ROUND
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    idx_t     pos;
    idx_t     pos2;
    count_t   fill;
    word_t    word;
    word_t    word_a;
    word_t    word_b;
    logic     phase;
    logic     swap_all;
  } cell_ctrl_t;

endpackage

### rtl/owle_cell.sv
// One list slot of the cell chain: load, shift, swap and compare-exchange.
module owle_cell (
  input  logic               clk,
  input  owle_pkg::idx_t     idx,
  input  owle_pkg::cell_ctrl_t ctrl,
  input  owle_pkg::word_t    left,
  input  owle_pkg::word_t    right,
  output owle_pkg::word_t    slot,
  output logic               hit
);
  import owle_pkg::*;

  count_t idx_ext;
  count_t idx_up;
  logic   pair_right;
  logic   pair_left;
  word_t  slot_next;

  assign idx_ext = count_t'(idx);
  assign idx_up  = idx_ext + count_t'(1);

  // Flag a live entry that matches the search word
  assign hit = (slot == ctrl.word) && (idx_ext < ctrl.fill);

  // Pairing for one round of odd-even transposition
  assign pair_right = (idx[0] == ctrl.phase) && (idx_up < ctrl.fill);
  assign pair_left  = (idx[0] != ctrl.phase) && (idx != '0) && (idx_ext < ctrl.fill);

  // Pick the next slot value
  always_comb begin
    slot_next = slot;
    case (ctrl.op)
      CELL_APPEND: begin
        if (idx_ext == ctrl.fill) slot_next = ctrl.word;
      end
      CELL_WRITE: begin
        if (idx == ctrl.pos) slot_next = ctrl.word;
      end
      CELL_REMOVE: begin
        if (idx >= ctrl.pos) slot_next = right;
      end
      CELL_INSERT: begin
        if (idx > ctrl.pos) slot_next = left;
        else if (idx == ctrl.pos) slot_next = ctrl.word;
      end
      CELL_SWAP: begin
        if (idx == ctrl.pos) slot_next = ctrl.word_b;
        else if (idx == ctrl.pos2) slot_next = ctrl.word_a;
      end
      CELL_ROUND: begin
        if (pair_right && (ctrl.swap_all || (slot > right))) slot_next = right;
        else if (pair_left && (ctrl.swap_all || (left > slot))) slot_next = left;
      end
      default: slot_next = slot;
    endcase
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

endmodule

### rtl/ordered_word_list_engine_core.sv
// Ordered word list engine: control, decode and the chain of slot cells.
//
//  channel | signals                      | carries
//  --------+------------------------------+-------------------------------
//  request | req_valid, req_ready, req    | mode, positions, word
//  result  | rsp_valid, rsp_ready, rsp    | status, word, index, count
//
// Append, read, write, find, remove, insert and clear act on the chain at transfer.
// Swap needs a second step: the chain has a single read port, so the first
// slot is read on transfer and the second in the following cycle.
// Sort and reverse follow the transfer with one transposition round per
// entry held (fill rounds, none when fewer than two entries are held).
// The result is registered on transfer; a stalled result blocks the next
// request. Reset empties the list; slot contents are not cleared.
module ordered_word_list_engine_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  owle_pkg::req_t     req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output owle_pkg::rsp_t     rsp
);
  import owle_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SORT = 3'b010,
    S_SWAP = 3'b100
  } state_t;

  state_t     state;
  state_t     state_next;
  count_t     fill;
  count_t     count;
  logic       swap_all;
  idx_t       pos_q;
  idx_t       pos2_q;
  word_t      tmp_q;

  logic       req_fire;
  cell_ctrl_t ctrl;
  word_t      slot_q  [CAPACITY];
  word_t      left_w  [CAPACITY];
  word_t      right_w [CAPACITY];
  logic [CAPACITY-1:0] hits;
  idx_t       rd_addr;
  word_t      rd_word;
  idx_t       hit_idx;

  cell_op_t   dec_op;
  status_t    dec_status;
  word_t      dec_word;
  idx_t       dec_at;
  count_t     dec_fill;
  logic       dec_rounds;
  logic       dec_rev;
  logic       dec_swap;
  count_t     pos_ext;
  count_t     pos2_ext;
  count_t     last_round;

  assign req_ready = !rst && (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign req_fire  = req_valid && req_ready;
  assign pos_ext   = count_t'(req.position);
  assign pos2_ext  = count_t'(req.other_position);
  assign last_round = fill - count_t'(1);

  // Single read port into the chain
  assign rd_addr = (state == S_SWAP) ? pos2_q : req.position;
  assign rd_word = slot_q[rd_addr];

  // First matching live entry
  always_comb begin
    hit_idx = '0;
    for (int k = CAPACITY - 1; k >= 0; k--) begin
      if (hits[k]) hit_idx = idx_t'(k);
    end
  end

  // Decode the request into a cell operation and a result
  always_comb begin
    dec_op     = CELL_HOLD;
    dec_status = ST_OK;
    dec_word   = '0;
    dec_at     = '0;
    dec_fill   = fill;
    dec_rounds = 1'b0;
    dec_rev    = 1'b0;
    dec_swap   = 1'b0;
    case (req.mode)
      MODE_APPEND: begin
        if (fill >= count_t'(CAPACITY)) dec_status = ST_FULL;
        else begin
          dec_op   = CELL_APPEND;
          dec_fill = fill + count_t'(1);
        end
      end
      MODE_READ: begin
        if (pos_ext >= fill) dec_status = ST_RANGE;
        else dec_word = rd_word;
      end
      MODE_WRITE: begin
        if (pos_ext >= fill) dec_status = ST_RANGE;
        else dec_op = CELL_WRITE;
      end
      MODE_FIND: begin
        if (|hits) dec_at = hit_idx;
        else dec_status = ST_MISSING;
      end
      MODE_REMOVE: begin
        if (pos_ext >= fill) dec_status = ST_RANGE;
        else begin
          dec_op   = CELL_REMOVE;
          dec_word = rd_word;
          dec_fill = fill - count_t'(1);
        end
      end
      MODE_INSERT: begin
        if (fill >= count_t'(CAPACITY)) dec_status = ST_FULL;
        else if (pos_ext > fill) dec_status = ST_RANGE;
        else begin
          dec_op   = CELL_INSERT;
          dec_fill = fill + count_t'(1);
        end
      end
      MODE_SWAP: begin
        if ((pos_ext >= fill) || (pos2_ext >= fill)) dec_status = ST_RANGE;
        else dec_swap = 1'b1;
      end
      MODE_SORT: begin
        dec_rounds = (fill >= count_t'(2));
      end
      MODE_REVERSE: begin
        if (fill == '0) dec_status = ST_RANGE;
        else begin
          dec_rounds = (fill >= count_t'(2));
          dec_rev    = 1'b1;
        end
      end
      MODE_CLEAR: begin
        dec_fill = '0;
      end
      default: dec_status = ST_RANGE;
    endcase
  end

  // Drive the chain: rounds and the swap write win over a new request
  always_comb begin
    ctrl.pos      = req.position;
    ctrl.pos2     = req.other_position;
    ctrl.fill     = fill;
    ctrl.word     = req.word_in;
    ctrl.word_a   = tmp_q;
    ctrl.word_b   = rd_word;
    ctrl.phase    = count[0];
    ctrl.swap_all = swap_all;
    ctrl.op       = CELL_HOLD;
    case (state)
      S_SORT: ctrl.op = CELL_ROUND;
      S_SWAP: begin
        ctrl.op   = CELL_SWAP;
        ctrl.pos  = pos_q;
        ctrl.pos2 = pos2_q;
      end
      S_IDLE: begin
        if (req_fire) ctrl.op = dec_op;
      end
      default: ctrl.op = CELL_HOLD;
    endcase
  end

  // Advance the sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_fire && dec_rounds) state_next = S_SORT;
        else if (req_fire && dec_swap) state_next = S_SWAP;
      end
      S_SORT: begin
        if (count == last_round) state_next = S_IDLE;
      end
      S_SWAP: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (req_fire) begin
        fill      <= dec_fill;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (state == S_SORT) count <= count + count_t'(1);
      else count <= '0;
    end
  end

  // Hold the result and the operands of a swap, sort or reverse
  always_ff @(posedge clk) begin
    if (req_fire) begin
      rsp.status   <= dec_status;
      rsp.word_out <= dec_word;
      rsp.found_at <= dec_at;
      rsp.entries  <= dec_fill;
      swap_all     <= dec_rev;
      pos_q        <= req.position;
      pos2_q       <= req.other_position;
      tmp_q        <= rd_word;
    end
  end

  // Chain of slot cells, each wired to its neighbours
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign left_w[k] = '0;
    end else begin : g_mid_l
      assign left_w[k] = slot_q[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_w[k] = '0;
    end else begin : g_mid_r
      assign right_w[k] = slot_q[k+1];
    end
    owle_cell u_cell (
      .clk   (clk),
      .idx   (idx_t'(k)),
      .ctrl  (ctrl),
      .left  (left_w[k]),
      .right (right_w[k]),
      .slot  (slot_q[k]),
      .hit   (hits[k])
    );
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= count_t'(CAPACITY))
    else $error("list count above capacity");

  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SORT) |-> (count < fill))
    else $error("transposition round beyond list length");

  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !req_ready)
    else $error("request taken while chain busy");

  a_sort_start: assert property (@(posedge clk) disable iff (rst)
    (req_fire && (req.mode == MODE_SORT) && (fill >= count_t'(2))) |=> (state == S_SORT))
    else $error("sort did not start its rounds");

  a_count_match: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.entries == fill))
    else $error("reported count differs from held count");
`endif

endmodule

### test/ordered_word_list_engine_core_tb.sv
// Self-checking testbench for the ordered word list engine core.
module ordered_word_list_engine_core_tb;
  import owle_pkg::*;

  // Mode codes the block does not define; both must come back as a range error
  localparam mode_t MODE_UNUSED_LO = 4'd10;
  localparam mode_t MODE_UNUSED_HI = 4'd15;

  localparam int RANDOM_ITEMS = 1400;
  localparam int IDLE_PCT     = 38;
  localparam int CALM_FIRST   = 500;
  localparam int CALM_LAST    = 700;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 250;
  localparam int STUCK_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  ordered_word_list_engine_core uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #1 clk = ~clk;

  // Requests waiting to be driven and results still owed by the block
  req_t  pending_reqs[$];
  rsp_t  owed_results[$];
  word_t word_pool[$];

  // Shadow of the list as the block should hold it
  word_t  list_slots[CAPACITY];
  count_t list_fill = '0;

  int  plan_fill = 0;
  int  issued = 0;
  int  results_seen = 0;
  int  error_count = 0;
  int  status_tally[4] = '{0, 0, 0, 0};
  int  deepest_fill = 0;
  int  hold_left = 0;
  int  stuck_cycles = 0;
  bit  held_once = 1'b0;
  bit  req_taken = 1'b0;
  bit  calm;

  assign calm = (issued >= CALM_FIRST) && (issued < CALM_LAST);

  // Apply one request to the shadow list and return the result it must give
  function automatic rsp_t apply_list_op(req_t r);
    rsp_t  o;
    word_t t;
    int    n;
    int    k;
    int    j;
    o = '0;
    o.status = ST_OK;
    n = list_fill;
    case (r.mode)
      MODE_APPEND: begin
        if (n >= CAPACITY) o.status = ST_FULL;
        else begin
          list_slots[n] = r.word_in;
          list_fill = list_fill + 1'b1;
        end
      end
      MODE_READ: begin
        if (r.position >= n) o.status = ST_RANGE;
        else o.word_out = list_slots[r.position];
      end
      MODE_WRITE: begin
        if (r.position >= n) o.status = ST_RANGE;
        else list_slots[r.position] = r.word_in;
      end
      MODE_FIND: begin
        o.status = ST_MISSING;
        for (k = n - 1; k >= 0; k--) begin
          if (list_slots[k] == r.word_in) begin
            o.status = ST_OK;
            o.found_at = idx_t'(k);
          end
        end
      end
      MODE_REMOVE: begin
        if (r.position >= n) o.status = ST_RANGE;
        else begin
          o.word_out = list_slots[r.position];
          for (k = r.position; k + 1 < n; k++) list_slots[k] = list_slots[k+1];
          list_fill = list_fill - 1'b1;
        end
      end
      MODE_INSERT: begin
        if (n >= CAPACITY) o.status = ST_FULL;
        else if (r.position > n) o.status = ST_RANGE;
        else begin
          for (k = n; k > r.position; k--) list_slots[k] = list_slots[k-1];
          list_slots[r.position] = r.word_in;
          list_fill = list_fill + 1'b1;
        end
      end
      MODE_SWAP: begin
        if (r.position >= n || r.other_position >= n) o.status = ST_RANGE;
        else begin
          t = list_slots[r.position];
          list_slots[r.position] = list_slots[r.other_position];
          list_slots[r.other_position] = t;
        end
      end
      MODE_SORT: begin
        for (k = 1; k < n; k++) begin
          for (j = n - 1; j >= k; j--) begin
            if (list_slots[j-1] > list_slots[j]) begin
              t = list_slots[j];
              list_slots[j] = list_slots[j-1];
              list_slots[j-1] = t;
            end
          end
        end
      end
      MODE_REVERSE: begin
        if (n == 0) o.status = ST_RANGE;
        else begin
          for (k = 0, j = n - 1; k < j; k++, j--) begin
            t = list_slots[k];
            list_slots[k] = list_slots[j];
            list_slots[j] = t;
          end
        end
      end
      MODE_CLEAR: list_fill = '0;
      default: o.status = ST_RANGE;
    endcase
    o.entries = list_fill;
    return o;
  endfunction

  // Queue one request and track the count it leaves behind
  task automatic add_item(mode_t m, idx_t p, idx_t p2, word_t w);
    req_t r;
    r.mode = m;
    r.position = p;
    r.other_position = p2;
    r.word_in = w;
    pending_reqs.push_back(r);
    case (m)
      MODE_APPEND: if (plan_fill < CAPACITY) plan_fill++;
      MODE_INSERT: if (plan_fill < CAPACITY && p <= plan_fill) plan_fill++;
      MODE_REMOVE: if (p < plan_fill) plan_fill--;
      MODE_CLEAR:  plan_fill = 0;
      default: ;
    endcase
    if (m == MODE_APPEND || m == MODE_WRITE || m == MODE_INSERT) begin
      word_pool.push_back(w);
      if (word_pool.size() > 16) void'(word_pool.pop_front());
    end
  endtask

  // Mix extremes, small repeating values, recent values and full random words
  function automatic word_t pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r <= 4 && word_pool.size() > 0)
      return word_pool[$urandom_range(0, word_pool.size() - 1)];
    if (r <= 6) return word_t'($urandom_range(0, 7));
    return word_t'($urandom);
  endfunction

  // Mostly a position inside the list, sometimes anywhere
  function automatic idx_t pick_pos(bit at_end);
    int top;
    top = at_end ? plan_fill : plan_fill - 1;
    if (top > CAPACITY - 1) top = CAPACITY - 1;
    if (top < 0 || $urandom_range(0, 99) < 15) return idx_t'($urandom_range(0, 15));
    return idx_t'($urandom_range(0, top));
  endfunction

  // Build the stimulus, release reset and wait for the last result
  initial begin
    int    grow;
    int    span;
    int    r;
    int    k;
    mode_t m;

    // Empty list corner cases
    add_item(MODE_READ, 4'd0, 4'd0, '0);
    add_item(MODE_REMOVE, 4'd0, 4'd0, '0);
    add_item(MODE_REVERSE, 4'd0, 4'd0, '0);
    add_item(MODE_FIND, 4'd0, 4'd0, '0);
    add_item(MODE_SWAP, 4'd0, 4'd0, '0);
    add_item(MODE_SORT, 4'd0, 4'd0, '0);
    // Grow to one short of full: extremes, insert past the end, at the front and at the end
    add_item(MODE_APPEND, 4'd0, 4'd0, '1);
    add_item(MODE_APPEND, 4'd15, 4'd15, '0);
    add_item(MODE_INSERT, 4'd15, 4'd0, 32'h1234_5678);
    add_item(MODE_INSERT, 4'd0, 4'd0, 32'h8000_0000);
    add_item(MODE_INSERT, 4'd3, 4'd0, 32'h0000_0001);
    for (k = 0; k < 11; k++) add_item(MODE_APPEND, 4'd0, 4'd0, word_t'($urandom));
    // Fill the list, then every other operation on it
    add_item(MODE_APPEND, 4'd0, 4'd0, 32'hDEAD_BEEF);
    add_item(MODE_INSERT, 4'd15, 4'd0, 32'hDEAD_BEEF);
    add_item(MODE_READ, 4'd15, 4'd0, '0);
    add_item(MODE_WRITE, 4'd15, 4'd0, '1);
    add_item(MODE_FIND, 4'd0, 4'd0, '1);
    add_item(MODE_FIND, 4'd0, 4'd0, 32'h5A5A_A5A5);
    add_item(MODE_SWAP, 4'd0, 4'd15, '0);
    add_item(MODE_SORT, 4'd0, 4'd0, '0);
    add_item(MODE_REVERSE, 4'd0, 4'd0, '0);
    add_item(MODE_REMOVE, 4'd0, 4'd0, '0);
    add_item(MODE_REMOVE, 4'd15, 4'd0, '0);
    add_item(MODE_UNUSED_LO, 4'd0, 4'd0, '0);
    add_item(MODE_UNUSED_HI, 4'd15, 4'd15, '1);
    add_item(MODE_CLEAR, 4'd0, 4'd0, '0);
    add_item(MODE_READ, 4'd0, 4'd0, '0);

    // Random episodes, each with its own bias towards growing the list
    while (pending_reqs.size() < RANDOM_ITEMS + 30) begin
      grow = 25 + 20 * $urandom_range(0, 2);
      span = $urandom_range(20, 80);
      if ($urandom_range(0, 2) == 0)
        add_item(MODE_CLEAR, pick_pos(1'b0), pick_pos(1'b0), pick_word());
      for (k = 0; k < span; k++) begin
        r = $urandom_range(0, 99);
        if (r < grow) m = $urandom_range(0, 1) ? MODE_APPEND : MODE_INSERT;
        else begin
          r = $urandom_range(0, 99);
          if (r < 15)      m = MODE_READ;
          else if (r < 30) m = MODE_WRITE;
          else if (r < 45) m = MODE_FIND;
          else if (r < 63) m = MODE_REMOVE;
          else if (r < 77) m = MODE_SWAP;
          else if (r < 84) m = MODE_SORT;
          else if (r < 91) m = MODE_REVERSE;
          else if (r < 95) m = MODE_CLEAR;
          else             m = mode_t'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
        end
        add_item(m, pick_pos(m == MODE_INSERT), pick_pos(1'b0), pick_word());
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || req_valid || owed_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (owed_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, owed_results.size());
      error_count++;
    end

    $display("%0d requests, %0d results checked, list grew to %0d entries",
             issued, results_seen, deepest_fill);
    $display("status mix: ok %0d, full %0d, range %0d, not found %0d",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
    if (error_count == 0) $display("ordered_word_list_engine_core_tb: done, clean");
    else $display("ordered_word_list_engine_core_tb: done, errors");
    $finish;
  end

  // Offer the next request, idling at random outside the calm stretch
  always @(negedge clk) begin : drive
    bit idle;
    idle = !calm && ($urandom_range(0, 99) < IDLE_PCT);
    if (!rst && (!req_valid || req_taken)) begin
      if (pending_reqs.size() != 0 && !idle) begin
        req <= pending_reqs.pop_front();
        req_valid <= 1'b1;
        issued++;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Accept results, with one long hold-off to back the block up
  always @(negedge clk) begin : accept
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else if (!held_once && issued >= HOLD_AT) begin
      held_once = 1'b1;
      hold_left = HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Predict on each request transfer and check each result transfer
  always @(posedge clk) begin : watch
    rsp_t want;
    req_taken <= !rst && req_valid && req_ready;
    if (!rst && req_valid && req_ready) begin
      want = apply_list_op(req);
      owed_results.push_back(want);
      status_tally[want.status]++;
      if (want.entries > deepest_fill) deepest_fill = want.entries;
    end
    if (!rst && rsp_valid && rsp_ready) begin
      results_seen++;
      if (owed_results.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d word %h at %0d entries %0d",
                 $time, rsp.status, rsp.word_out, rsp.found_at, rsp.entries);
        error_count++;
      end else begin
        want = owed_results.pop_front();
        if (rsp.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, rsp.status);
          error_count++;
        end
        if (rsp.word_out !== want.word_out) begin
          $display("%0t: word_out expected %h got %h", $time, want.word_out, rsp.word_out);
          error_count++;
        end
        if (rsp.found_at !== want.found_at) begin
          $display("%0t: found_at expected %0d got %0d", $time, want.found_at, rsp.found_at);
          error_count++;
        end
        if (rsp.entries !== want.entries) begin
          $display("%0t: entries expected %0d got %0d", $time, want.entries, rsp.entries);
          error_count++;
        end
      end
    end
  end

  // Abort when neither channel has moved for too long
  always @(posedge clk) begin : watchdog
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
      $display("ordered_word_list_engine_core_tb: done, errors");
      $finish;
    end
  end

endmodule
